>>> rtl/core/cfim_pkg.sv
`timescale 1ns / 1ps

package cfim_pkg;

    localparam int SCAN_ENTRIES = 32;
    localparam int RING_DEPTH   = 64;

    localparam int SCAN_AW = (SCAN_ENTRIES > 1) ? $clog2(SCAN_ENTRIES) : 1;
    localparam int SCAN_FW = $clog2(SCAN_ENTRIES + 1);
    localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RING_CW = $clog2(RING_DEPTH + 1);
    localparam int RING_SW = RING_CW + 1;

    localparam logic [2:0] KIND_FRAME     = 3'd0;
    localparam logic [2:0] KIND_POP       = 3'd1;
    localparam logic [2:0] KIND_READ      = 3'd2;
    localparam logic [2:0] KIND_SCAN_RST  = 3'd3;
    localparam logic [2:0] KIND_RING_RST  = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FILLED = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    localparam logic [1:0] CFG_SCAN_EN    = 2'd0;
    localparam logic [1:0] CFG_SCAN_BUS   = 2'd1;
    localparam logic [1:0] CFG_MON_EN     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic        bus;
        logic        is_ext;
        logic [28:0] frame_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [31:0] time_ms;
        logic [4:0]  entry_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rx_total;
        logic [5:0]  scan_entries;
        logic        out_bus;
        logic        out_is_ext;
        logic [28:0] out_id;
        logic [3:0]  out_dlc;
        logic [63:0] out_payload;
        logic [31:0] out_time_ms;
        logic [31:0] entry_hits;
    } t_out;

    typedef struct packed {
        logic [29:0] key;
        logic [31:0] hits;
    } t_scan_ent;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [3:0]  dlc;
        logic        bus;
        logic        is_ext;
        logic [28:0] id;
        logic [63:0] data;
    } t_ring_ent;

endpackage

>>> rtl/core/can_frame_id_stats_and_monitor.sv
`timescale 1ns / 1ps

// Result in the cycle after start for frames without scan, restarts, failed pops/reads
// and a first scan entry; pop and scan read pass the memory read and result registers;
// a scanned frame compares one table entry per cycle through the scan memory. No new
// command is taken while busy; busy is low in the cycle after the last compare.
// Reset: synchronous active low; clears counters, fill, ring pointers and config.
// The receiver cannot stall: each result is shown for exactly one cycle.
module can_frame_id_stats_and_monitor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cfim_pkg::t_in   i_in,
    output logic            o_valid,
    output cfim_pkg::t_out  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic            i_cfg_data
);
    import cfim_pkg::*;

    t_state r_state, n_state;

    logic r_scan_en, r_scan_bus, r_mon_en;

    logic [31:0]        r_total [2];
    logic [31:0]        n_total [2];
    logic [SCAN_FW-1:0] r_fill, n_fill;
    logic [SCAN_AW-1:0] r_cidx, n_cidx;
    logic [RING_AW-1:0] r_wptr, n_wptr;
    logic [RING_CW-1:0] r_count, n_count;
    logic               r_bus;
    logic [29:0]        r_key;
    logic               r_valid, n_valid;
    t_out               r_out, n_out;

    t_scan_ent          r_scan_mem [SCAN_ENTRIES];
    t_scan_ent          r_scan_q;
    logic               scan_we, scan_re;
    logic [SCAN_AW-1:0] scan_waddr, scan_raddr;
    t_scan_ent          scan_wdata;

    t_ring_ent          r_ring_mem [RING_DEPTH];
    t_ring_ent          r_ring_q;
    logic               ring_we, ring_re;
    logic [RING_AW-1:0] ring_raddr;
    t_ring_ent          ring_wdata;

    logic [28:0]        in_id;
    logic [29:0]        in_key;
    logic [RING_SW-1:0] rd_sum;
    logic               accept;
    logic               bus_sel;
    logic [SCAN_AW-1:0] cidx_inc;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_valid     = r_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_id    = i_in.is_ext ? i_in.frame_id : {18'd0, i_in.frame_id[10:0]};
    assign in_key   = {i_in.is_ext, in_id};
    assign cidx_inc = r_cidx + SCAN_AW'(1);

    always_comb begin
        rd_sum = RING_SW'(r_wptr) + RING_SW'(RING_DEPTH) - RING_SW'(r_count);
        if (rd_sum >= RING_SW'(RING_DEPTH)) begin
            rd_sum = rd_sum - RING_SW'(RING_DEPTH);
        end
        ring_raddr = rd_sum[RING_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_en  <= 1'b0;
            r_scan_bus <= 1'b0;
            r_mon_en   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCAN_EN:  r_scan_en  <= i_cfg_data;
                CFG_SCAN_BUS: r_scan_bus <= i_cfg_data;
                CFG_MON_EN:   r_mon_en   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_fill     = r_fill;
        n_cidx     = r_cidx;
        n_wptr     = r_wptr;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_out      = '0;
        scan_we    = 1'b0;
        scan_re    = 1'b0;
        scan_waddr = '0;
        scan_raddr = '0;
        scan_wdata = '0;
        ring_we    = 1'b0;
        ring_re    = 1'b0;
        ring_wdata = '0;
        bus_sel    = r_bus;

        case (r_state)
            ST_IDLE: begin
                bus_sel = i_in.bus;
                if (accept) begin
                    case (i_in.kind)
                        KIND_FRAME: begin
                            n_total[i_in.bus] = r_total[i_in.bus] + 32'd1;
                            if (r_mon_en) begin
                                ring_we    = 1'b1;
                                ring_wdata = '{time_ms: i_in.time_ms, dlc: i_in.dlc,
                                               bus: i_in.bus, is_ext: i_in.is_ext,
                                               id: in_id, data: i_in.payload};
                                n_wptr = (32'(r_wptr) == RING_DEPTH - 1) ?
                                         '0 : r_wptr + RING_AW'(1);
                                if (32'(r_count) < RING_DEPTH) begin
                                    n_count = r_count + RING_CW'(1);
                                end
                            end
                            if (r_scan_en && (i_in.bus == r_scan_bus)) begin
                                if (r_fill == '0) begin
                                    scan_we          = 1'b1;
                                    scan_waddr       = '0;
                                    scan_wdata       = '{key: in_key, hits: 32'd1};
                                    n_fill           = SCAN_FW'(1);
                                    n_out.entry_hits = 32'd1;
                                    n_valid          = 1'b1;
                                end else begin
                                    scan_re    = 1'b1;
                                    scan_raddr = '0;
                                    n_cidx     = '0;
                                    n_state    = ST_SCAN;
                                end
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        KIND_POP: begin
                            if (r_count == '0) begin
                                n_out.status = STAT_EMPTY;
                                n_valid      = 1'b1;
                            end else begin
                                ring_re = 1'b1;
                                n_count = r_count - RING_CW'(1);
                                n_state = ST_POP;
                            end
                        end
                        KIND_READ: begin
                            if (32'(i_in.entry_index) < 32'(r_fill)) begin
                                scan_re    = 1'b1;
                                scan_raddr = SCAN_AW'(i_in.entry_index);
                                n_state    = ST_READ;
                            end else begin
                                n_out.status = STAT_NOT_FILLED;
                                n_valid      = 1'b1;
                            end
                        end
                        KIND_SCAN_RST: begin
                            n_fill  = '0;
                            n_valid = 1'b1;
                        end
                        KIND_RING_RST: begin
                            n_wptr  = '0;
                            n_count = '0;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_scan_q.key == r_key) begin
                    scan_we          = 1'b1;
                    scan_waddr       = r_cidx;
                    scan_wdata       = '{key: r_key, hits: r_scan_q.hits + 32'd1};
                    n_out.entry_hits = r_scan_q.hits + 32'd1;
                    n_valid          = 1'b1;
                    n_state          = ST_IDLE;
                end else if (32'(r_cidx) + 32'd1 == 32'(r_fill)) begin
                    if (32'(r_fill) < SCAN_ENTRIES) begin
                        scan_we          = 1'b1;
                        scan_waddr       = SCAN_AW'(r_fill);
                        scan_wdata       = '{key: r_key, hits: 32'd1};
                        n_fill           = r_fill + SCAN_FW'(1);
                        n_out.entry_hits = 32'd1;
                    end else begin
                        n_out.status = STAT_FULL;
                    end
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    scan_re    = 1'b1;
                    scan_raddr = cidx_inc;
                    n_cidx     = cidx_inc;
                end
            end
            ST_POP: begin
                n_out.out_bus     = r_ring_q.bus;
                n_out.out_is_ext  = r_ring_q.is_ext;
                n_out.out_id      = r_ring_q.id;
                n_out.out_dlc     = r_ring_q.dlc;
                n_out.out_payload = r_ring_q.data;
                n_out.out_time_ms = r_ring_q.time_ms;
                n_valid           = 1'b1;
                n_state           = ST_IDLE;
            end
            ST_READ: begin
                n_out.out_is_ext = r_scan_q.key[29];
                n_out.out_id     = r_scan_q.key[28:0];
                n_out.entry_hits = r_scan_q.hits;
                n_valid          = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out.rx_total     = n_total[bus_sel];
        n_out.scan_entries = 6'(n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_total[0] <= '0;
            r_total[1] <= '0;
            r_fill     <= '0;
            r_cidx     <= '0;
            r_wptr     <= '0;
            r_count    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_fill  <= n_fill;
            r_cidx  <= n_cidx;
            r_wptr  <= n_wptr;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_bus <= i_in.bus;
            r_key <= in_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_we) begin
            r_scan_mem[scan_waddr] <= scan_wdata;
        end
        if (scan_re) begin
            r_scan_q <= r_scan_mem[scan_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_mem[r_wptr] <= ring_wdata;
        end
        if (ring_re) begin
            r_ring_q <= r_ring_mem[ring_raddr];
        end
    end

endmodule

>>> rtl/core/cfim_chk.sv
`timescale 1ns / 1ps

module cfim_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            o_valid,
    input  cfim_pkg::t_out  o_out
);
    import cfim_pkg::*;

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted command neither answered nor in progress");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result without a pending command");

    a_fail_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.status == STAT_EMPTY || o_out.status == STAT_NOT_FILLED))
        |-> (o_out.out_id == '0 && o_out.out_payload == '0 && o_out.entry_hits == '0))
        else $error("failed pop or read carries data");

    a_full_no_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status == STAT_FULL) |-> (o_out.entry_hits == '0 &&
        32'(o_out.scan_entries) == (SCAN_ENTRIES % 64)))
        else $error("dropped ID reported with hits or partial table");

endmodule

bind can_frame_id_stats_and_monitor cfim_chk u_cfim_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_out   (o_out)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import cfim_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int         POOL_N        = 12;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         TAIL_CYCLES   = 40;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    t_in                    i_in        = '0;
    logic                   o_valid;
    t_out                   o_out;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index = CFG_SCAN_EN;
    logic                   i_cfg_data  = 1'b0;

    logic                   took        = 1'b0;
    int                     gap_pct     = 0;
    int                     cfg_writes  = 0;
    int                     stall_count = 0;
    int                     err_count   = 0;

    t_in                    cmd_backlog[$];
    t_out                   due_reports[$];
    logic [28:0]            id_pool[POOL_N];

    logic                   cfg_scan_en;
    logic                   cfg_scan_bus;
    logic                   cfg_mon_en;
    logic [31:0]            bus_total[2];
    logic [29:0]            scan_keys[SCAN_ENTRIES];
    logic [31:0]            scan_hits[SCAN_ENTRIES];
    int                     scan_fill;
    t_ring_ent              ring[RING_DEPTH];
    logic [RING_AW-1:0]     ring_wr;
    int                     ring_cnt;

    int                     n_frames    = 0;
    int                     n_repeats   = 0;
    int                     n_drops     = 0;
    int                     n_pops      = 0;
    int                     n_empty     = 0;
    int                     n_reads     = 0;
    int                     n_unfilled  = 0;

    can_frame_id_stats_and_monitor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out tally_cmd(input t_in c);
        t_out               r;
        logic [28:0]        id;
        logic [29:0]        key;
        logic [RING_AW-1:0] rd;
        int                 hit_at;
        r  = '0;
        id = c.is_ext ? c.frame_id : {18'd0, c.frame_id[10:0]};
        case (c.kind)
            KIND_FRAME: begin
                bus_total[c.bus] += 32'd1;
                n_frames++;
                if (cfg_scan_en && c.bus == cfg_scan_bus) begin
                    key    = {c.is_ext, id};
                    hit_at = -1;
                    for (int i = 0; i < scan_fill; i++)
                        if (hit_at < 0 && scan_keys[i] == key) hit_at = i;
                    if (hit_at >= 0) begin
                        scan_hits[hit_at] += 32'd1;
                        r.entry_hits = scan_hits[hit_at];
                        n_repeats++;
                    end else if (scan_fill < SCAN_ENTRIES) begin
                        scan_keys[scan_fill] = key;
                        scan_hits[scan_fill] = 32'd1;
                        scan_fill++;
                        r.entry_hits = 32'd1;
                    end else begin
                        r.status = STAT_FULL;
                        n_drops++;
                    end
                end
                if (cfg_mon_en) begin
                    ring[ring_wr].time_ms = c.time_ms;
                    ring[ring_wr].dlc     = c.dlc;
                    ring[ring_wr].bus     = c.bus;
                    ring[ring_wr].is_ext  = c.is_ext;
                    ring[ring_wr].id      = id;
                    ring[ring_wr].data    = c.payload;
                    ring_wr = ring_wr + 1'b1;
                    if (ring_cnt < RING_DEPTH) ring_cnt++;
                end
            end
            KIND_POP: begin
                if (ring_cnt == 0) begin
                    r.status = STAT_EMPTY;
                    n_empty++;
                end else begin
                    rd            = ring_wr - ring_cnt[RING_AW-1:0];
                    r.out_bus     = ring[rd].bus;
                    r.out_is_ext  = ring[rd].is_ext;
                    r.out_id      = ring[rd].id;
                    r.out_dlc     = ring[rd].dlc;
                    r.out_payload = ring[rd].data;
                    r.out_time_ms = ring[rd].time_ms;
                    ring_cnt--;
                    n_pops++;
                end
            end
            KIND_READ: begin
                if (c.entry_index < scan_fill) begin
                    r.out_is_ext = scan_keys[c.entry_index][29];
                    r.out_id     = scan_keys[c.entry_index][28:0];
                    r.entry_hits = scan_hits[c.entry_index];
                    n_reads++;
                end else begin
                    r.status = STAT_NOT_FILLED;
                    n_unfilled++;
                end
            end
            KIND_SCAN_RST: scan_fill = 0;
            KIND_RING_RST: begin
                ring_wr  = '0;
                ring_cnt = 0;
            end
            default: ;
        endcase
        r.rx_total     = bus_total[c.bus];
        r.scan_entries = scan_fill[5:0];
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
                i_in  <= cmd_backlog.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        logic moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid) begin
                moved = 1'b1;
                if (due_reports.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    err_count++;
                end else begin
                    want = due_reports.pop_front();
                    cmp_field("status",       want.status,       o_out.status);
                    cmp_field("rx_total",     want.rx_total,     o_out.rx_total);
                    cmp_field("scan_entries", want.scan_entries, o_out.scan_entries);
                    cmp_field("out_bus",      want.out_bus,      o_out.out_bus);
                    cmp_field("out_is_ext",   want.out_is_ext,   o_out.out_is_ext);
                    cmp_field("out_id",       want.out_id,       o_out.out_id);
                    cmp_field("out_dlc",      want.out_dlc,      o_out.out_dlc);
                    cmp_field("out_payload",  want.out_payload,  o_out.out_payload);
                    cmp_field("out_time_ms",  want.out_time_ms,  o_out.out_time_ms);
                    cmp_field("entry_hits",   want.entry_hits,   o_out.entry_hits);
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                due_reports.push_back(tally_cmd(i_in));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    CFG_SCAN_EN:  cfg_scan_en  = i_cfg_data;
                    CFG_SCAN_BUS: cfg_scan_bus = i_cfg_data;
                    CFG_MON_EN:   cfg_mon_en   = i_cfg_data;
                    default: ;
                endcase
                cfg_writes++;
            end
            took <= start && !busy;
            stall_count = moved ? 0 : stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic val);
        int target;
        @(negedge i_clk);
        target = cfg_writes + 1;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        while (cfg_writes != target) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic scan_en, input logic scan_bus, input logic mon_en);
        write_reg(CFG_SCAN_EN, scan_en);
        write_reg(CFG_SCAN_BUS, scan_bus);
        write_reg(CFG_MON_EN, mon_en);
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || due_reports.size() != 0 || start || busy)
            @(negedge i_clk);
    endtask

    function automatic t_in mk_cmd(input logic [2:0] kind, input logic bus,
                                   input logic is_ext, input logic [28:0] id,
                                   input logic [3:0] dlc, input logic [63:0] data,
                                   input logic [31:0] tms, input logic [4:0] idx);
        t_in c;
        c.kind        = kind;
        c.bus         = bus;
        c.is_ext      = is_ext;
        c.frame_id    = id;
        c.dlc         = dlc;
        c.payload     = data;
        c.time_ms     = tms;
        c.entry_index = idx;
        return c;
    endfunction

    function automatic t_in random_cmd(input int pop_pct);
        t_in c;
        int  roll;
        roll = $urandom_range(99);
        if (roll < pop_pct)           c.kind = KIND_POP;
        else if (roll < pop_pct + 12) c.kind = KIND_READ;
        else if (roll < pop_pct + 13) c.kind = KIND_SCAN_RST;
        else if (roll < pop_pct + 14) c.kind = KIND_RING_RST;
        else if (roll < pop_pct + 17)
            c.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        else                          c.kind = KIND_FRAME;
        c.bus         = 1'($urandom_range(1));
        c.is_ext      = 1'($urandom_range(1));
        c.frame_id    = $urandom_range(1) ? id_pool[$urandom_range(POOL_N - 1)]
                                          : 29'($urandom);
        c.dlc         = 4'($urandom_range(15));
        c.payload     = {$urandom, $urandom};
        c.time_ms     = $urandom;
        c.entry_index = 5'($urandom_range(31));
        return c;
    endfunction

    task automatic run_phase(input int gap, input logic scan_en, input logic scan_bus,
                             input logic mon_en, input int pop_pct, input int n);
        drain();
        set_regs(scan_en, scan_bus, mon_en);
        gap_pct = gap;
        for (int i = 0; i < n; i++) cmd_backlog.push_back(random_cmd(pop_pct));
        drain();
    endtask

    initial begin
        cfg_scan_en  = 1'b0;
        cfg_scan_bus = 1'b0;
        cfg_mon_en   = 1'b0;
        bus_total[0] = '0;
        bus_total[1] = '0;
        scan_fill    = 0;
        ring_wr      = '0;
        ring_cnt     = 0;
        for (int i = 0; i < POOL_N; i++) id_pool[i] = 29'($urandom);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_regs(1'b1, 1'b0, 1'b1);
        cmd_backlog.push_back(mk_cmd(KIND_POP,   1'b0, 1'b0, '0, '0, '0, '0, 5'd0));
        cmd_backlog.push_back(mk_cmd(KIND_READ,  1'b0, 1'b0, '0, '0, '0, '0, 5'd0));
        cmd_backlog.push_back(mk_cmd(KIND_FRAME, 1'b0, 1'b0, '1, '1, '1, '1, '0));
        cmd_backlog.push_back(mk_cmd(KIND_FRAME, 1'b0, 1'b1, '1, '0, '0, '0, '1));
        cmd_backlog.push_back(mk_cmd(KIND_FRAME, 1'b0, 1'b1, '1, 4'd8,
                                     64'h0123_4567_89AB_CDEF, 32'h8000_0000, '0));
        cmd_backlog.push_back(mk_cmd(KIND_FRAME, 1'b0, 1'b0, 29'h1FFF_F7FF, 4'd7,
                                     64'hFEDC_BA98_7654_3210, 32'd1, '0));
        cmd_backlog.push_back(mk_cmd(KIND_FRAME, 1'b1, 1'b1, '0, 4'd1, 64'd1, 32'd2, '0));
        cmd_backlog.push_back(mk_cmd(KIND_READ,  1'b0, 1'b0, '0, '0, '0, '0, 5'd0));
        cmd_backlog.push_back(mk_cmd(KIND_READ,  1'b1, 1'b0, '0, '0, '0, '0, 5'd1));
        cmd_backlog.push_back(mk_cmd(KIND_READ,  1'b0, 1'b0, '0, '0, '0, '0, 5'd31));
        repeat (6) cmd_backlog.push_back(mk_cmd(KIND_POP, 1'b1, 1'b0, '0, '0, '0, '0, '0));
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            cmd_backlog.push_back(mk_cmd(3'(k), 1'b1, 1'b1, '1, '1, '1, '1, '1));
        cmd_backlog.push_back(mk_cmd(KIND_SCAN_RST, 1'b0, 1'b0, '0, '0, '0, '0, '0));
        cmd_backlog.push_back(mk_cmd(KIND_READ,  1'b0, 1'b0, '0, '0, '0, '0, 5'd0));
        cmd_backlog.push_back(mk_cmd(KIND_FRAME, 1'b0, 1'b1, 29'h0ABC_DEF0, 4'd3,
                                     64'hA5A5_5A5A_A5A5_5A5A, 32'd100, '0));
        cmd_backlog.push_back(mk_cmd(KIND_RING_RST, 1'b1, 1'b0, '0, '0, '0, '0, '0));
        cmd_backlog.push_back(mk_cmd(KIND_POP,   1'b0, 1'b0, '0, '0, '0, '0, '0));
        drain();

        run_phase(0,  1'b1, 1'b0, 1'b1, 15, 285);
        run_phase(86, 1'b1, 1'b1, 1'b1, 50, 285);
        run_phase(7,  1'b0, 1'b0, 1'b0, 20, 285);
        run_phase(0,  1'b1, 1'b1, 1'b0, 10, 285);
        run_phase(86, 1'b0, 1'b1, 1'b1, 50, 285);
        run_phase(7,  1'b1, 1'b0, 1'b1, 30, 285);
        run_phase(0,  1'b1, 1'b1, 1'b1, 15, 285);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_reports.size() != 0) begin
            $error("%0d expected results never arrived", due_reports.size());
            err_count++;
        end
        $display("covered %0d frames (%0d repeat IDs, %0d dropped on full table)",
                 n_frames, n_repeats, n_drops);
        $display("ring pops %0d ok / %0d empty, scan reads %0d ok / %0d unfilled",
                 n_pops, n_empty, n_reads, n_unfilled);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/cfim_pkg.sv
rtl/core/can_frame_id_stats_and_monitor.sv
rtl/core/cfim_chk.sv
verif/tb.sv
